// ===== rtl/core/prh_pkg.sv =====
// prh_pkg: shared types, constants and mixing functions for the pose record hash
// used by prh_round, prh_finish and pose_record_hash; no dependencies

package prh_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned ReqWidth    = 40;   // word and count, padded to whole bytes

   localparam logic [LengthWidth-1:0] LengthReset = 16'd64;

   // byte counts that select a tail rule
   localparam logic [CountWidth-1:0] CountNone  = 3'd0;
   localparam logic [CountWidth-1:0] CountOne   = 3'd1;
   localparam logic [CountWidth-1:0] CountTwo   = 3'd2;
   localparam logic [CountWidth-1:0] CountThree = 3'd3;

   typedef logic [WordWidth-1:0] word_type;

   // transfer from the round stage to the finishing pipeline
   typedef struct packed {
      logic     valid;
      word_type value;
   } fin_type;

   function automatic word_type sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic word_type sext8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   // one round over a full four-byte word
   function automatic word_type full_round(input word_type c_in, input word_type w);
      word_type c;
      word_type hi;
      c  = c_in + sext16(w[15:0]);
      hi = sext16(w[31:16]) ^ (c << 5);
      hi = hi << 11;
      c  = c ^ hi;
      c  = c + word_type'($signed(c) >>> 11);
      return c;
   endfunction

   // tail rules for a short last word
   function automatic word_type tail_round(input word_type c_in, input word_type w,
                                           input logic [CountWidth-1:0] n);
      word_type c;
      word_type t;
      c = c_in;
      t = '0;
      case (n)
         CountThree: begin
            c = c + sext16(w[15:0]);
            t = (sext8(w[23:16]) << 2) ^ c;
            c = c ^ (t << 16);
            c = c + word_type'($signed(c) >>> 11);
         end
         CountTwo: begin
            c = c + sext16(w[15:0]);
            c = c ^ (c << 11);
            c = c + word_type'($signed(c) >>> 17);
         end
         default: begin
            c = c + sext8(w[7:0]);
            c = c ^ (c << 10);
            c = c + word_type'($signed(c) >>> 1);
         end
      endcase
      return c;
   endfunction

   // first four avalanche steps
   function automatic word_type mix_early(input word_type c_in);
      word_type c;
      c = c_in ^ (c_in << 3);
      c = c + word_type'($signed(c) >>> 5);
      c = c ^ (c << 4);
      c = c + word_type'($signed(c) >>> 17);
      return c;
   endfunction

   // last two avalanche steps
   function automatic word_type mix_late(input word_type c_in);
      word_type c;
      c = c_in ^ (c_in << 25);
      c = c + word_type'($signed(c) >>> 6);
      return c;
   endfunction

endpackage

// ===== rtl/core/pose_record_hash.sv =====
// pose_record_hash: top level of the streaming shift-add-xor message hash
// depends on prh_pkg, prh_round and prh_finish
//
// Usage:
//   req_* carries the message as 32-bit little-endian words, one per transfer;
//   tdata holds the word and its byte count, tlast marks the final word.
//   rsp_* returns one 32-bit hash per message, after its last word.
//   csr_* writes the message length that seeds each message; write it only
//   while no message is in flight.
// Pipeline and throughput:
//   one word is taken every cycle while req_tready is high. A last word passes
//   the input register and round, then two avalanche stages, then the
//   result register before its hash shows on rsp_tvalid. The loop through the
//   accumulator is one round per cycle and sets the rate.
// Reset:
//   synchronous; all stages empty, accumulator cleared, length back to 64.
// Stalls:
//   a stalled result holds in the result register while the two avalanche
//   stages and the input register keep filling; req_tready drops only when a
//   last word cannot move on into a full pipeline.

module pose_record_hash import prh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqWidth-1:0]    req_tdata,    // data_word[31:0], byte_count[34:32], zero pad
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,    // hash_value[31:0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LengthWidth-1:0] csr_wdata     // message_length[15:0]
);

   logic [LengthWidth-1:0] length_ff, length_in;
   fin_type                fin;
   logic                   fin_ready;

   // length register, a write always completes in one transfer
   assign csr_ready = 1'b1;
   assign length_in = (csr_valid && csr_ready) ? csr_wdata : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LengthReset;
      end else begin
         length_ff <= length_in;
      end
   end

   prh_round u_round (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .message_length (length_ff),
      .fin            (fin),
      .fin_ready      (fin_ready)
   );

   prh_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .fin        (fin),
      .fin_ready  (fin_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/prh_round.sv =====
// prh_round: input register, running accumulator and per-word round logic
// depends on prh_pkg

module prh_round import prh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqWidth-1:0]    req_tdata,    // data_word[31:0], byte_count[34:32], zero pad
   input  logic                   req_tlast,
   input  logic [LengthWidth-1:0] message_length,
   output fin_type                fin,
   input  logic                   fin_ready
);

   logic                  s1_valid_ff, s1_valid_in;
   word_type              word_ff, word_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  last_ff, last_in;
   word_type              acc_ff, acc_in;
   logic                  mid_ff, mid_in;

   word_type seed;
   word_type rounded;
   logic     s1_go;
   logic     take;

   // round over the held word, seeded by the length on the first word
   always_comb begin
      seed = mid_ff ? acc_ff : {{(WordWidth-LengthWidth){1'b0}}, message_length};
      if (!last_ff || count_ff > CountThree) begin
         rounded = full_round(seed, word_ff);
      end else if (count_ff == CountNone) begin
         rounded = seed;
      end else begin
         rounded = tail_round(seed, word_ff, count_ff);
      end
   end

   // stage handshake
   assign s1_go      = s1_valid_ff && (!last_ff || fin_ready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign take       = req_tvalid && req_tready;

   assign fin.valid = s1_valid_ff && last_ff;
   assign fin.value = (message_length == '0) ? '0 : rounded;

   // next state
   always_comb begin
      s1_valid_in = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      word_in     = take ? req_tdata[WordWidth-1:0] : word_ff;
      count_in    = take ? req_tdata[WordWidth+CountWidth-1:WordWidth] : count_ff;
      last_in     = take ? req_tlast : last_ff;
      acc_in      = acc_ff;
      mid_in      = mid_ff;
      if (s1_go) begin
         if (last_ff) begin
            acc_in = '0;
            mid_in = 1'b0;
         end else begin
            acc_in = rounded;
            mid_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         mid_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
         mid_ff      <= mid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

endmodule

// ===== rtl/core/prh_finish.sv =====
// prh_finish: two avalanche stages and the result register
// depends on prh_pkg

module prh_finish import prh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  fin_type        fin,
   output logic           fin_ready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [31:0]    rsp_tdata     // hash_value[31:0]
);

   logic     s2_valid_ff, s2_valid_in;
   word_type s2_value_ff, s2_value_in;
   logic     s3_valid_ff, s3_valid_in;
   word_type s3_value_ff, s3_value_in;
   logic     out_valid_ff, out_valid_in;
   word_type out_value_ff, out_value_in;

   logic out_free;
   logic s3_free;
   logic s2_free;

   // each stage loads when empty or when it drains this cycle
   assign out_free  = !out_valid_ff || rsp_tready;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign fin_ready = s2_free;

   always_comb begin
      s2_valid_in  = s2_free ? fin.valid : s2_valid_ff;
      s2_value_in  = s2_free ? fin.value : s2_value_ff;
      s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
      s3_value_in  = s3_free ? mix_early(s2_value_ff) : s3_value_ff;
      out_valid_in = out_free ? s3_valid_ff : out_valid_ff;
      out_value_in = out_free ? mix_late(s3_value_ff) : out_value_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s2_value_ff  <= s2_value_in;
      s3_value_ff  <= s3_value_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;

endmodule

// ===== tb/prh_hash_checker.sv =====
`timescale 1ns / 100ps
// prh_hash_checker: watches the request, response and length-write channels of
// pose_record_hash, predicts each message hash and compares it; uses prh_pkg

module prh_hash_checker import prh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [ReqWidth-1:0]    req_tdata,    // data_word[31:0], byte_count[34:32], zero pad
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [31:0]            rsp_tdata,    // hash_value[31:0]
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [LengthWidth-1:0] csr_wdata,    // message_length[15:0]
   output int unsigned            failures,
   output int unsigned            pending
);

   // predicted copy of the block state
   logic [LengthWidth-1:0] length_reg;
   word_type               running_hash;
   logic                   in_message;
   word_type               hash_queue[$];
   int unsigned            fail_tally;

   // sign-filling right shift
   function automatic word_type sra32(input word_type x, input int unsigned s);
      logic signed [31:0] sx;
      sx = x;
      return word_type'(sx >>> s);
   endfunction

   function automatic word_type widen16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic word_type widen8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

   // four-byte word: low half added, shifted high half folded in
   function automatic word_type absorb_word(input word_type h, input word_type w);
      word_type upper;
      h     = h + widen16(w[15:0]);
      upper = (widen16(w[31:16]) ^ (h << 5)) << 11;
      h     = h ^ upper;
      return h + sra32(h, 11);
   endfunction

   // short last word with one, two or three bytes
   function automatic word_type absorb_tail(input word_type h, input word_type w,
                                            input logic [CountWidth-1:0] n);
      word_type mixed;
      if (n == CountThree) begin
         h     = h + widen16(w[15:0]);
         mixed = (widen8(w[23:16]) << 2) ^ h;
         h     = h ^ (mixed << 16);
         h     = h + sra32(h, 11);
      end else if (n == CountTwo) begin
         h = h + widen16(w[15:0]);
         h = h ^ (h << 11);
         h = h + sra32(h, 17);
      end else begin
         h = h + widen8(w[7:0]);
         h = h ^ (h << 10);
         h = h + sra32(h, 1);
      end
      return h;
   endfunction

   // six avalanche steps that close a message
   function automatic word_type avalanche_hash(input word_type h);
      h = h ^ (h << 3);
      h = h + sra32(h, 5);
      h = h ^ (h << 4);
      h = h + sra32(h, 17);
      h = h ^ (h << 25);
      h = h + sra32(h, 6);
      return h;
   endfunction

   // predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      word_type               want;
      word_type               word;
      word_type               h;
      logic [CountWidth-1:0]  count;
      if (reset) begin
         length_reg   = LengthReset;
         running_hash = '0;
         in_message   = 1'b0;
         hash_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hash_queue.size() == 0) begin
               $error("hash_value: expected none, got %08h", rsp_tdata);
               fail_tally++;
            end else begin
               want = hash_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $error("hash_value: expected %08h, got %08h", want, rsp_tdata);
                  fail_tally++;
               end
            end
         end
         if (csr_valid && csr_ready)
            length_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            word  = req_tdata[31:0];
            count = req_tdata[34:32];
            // first word of a message takes the length as seed
            if (!in_message) begin
               running_hash = word_type'(length_reg);
               in_message   = 1'b1;
            end
            h = running_hash;
            if (!req_tlast || count > CountThree)
               h = absorb_word(h, word);
            else if (count != CountNone)
               h = absorb_tail(h, word, count);
            if (!req_tlast) begin
               running_hash = h;
            end else begin
               h = avalanche_hash(h);
               if (length_reg == '0)
                  h = '0;
               hash_queue.push_back(h);
               running_hash = '0;
               in_message   = 1'b0;
            end
         end
      end
      failures <= fail_tally;
      pending  <= hash_queue.size();
   end

endmodule

// ===== tb/tb_pose_record_hash.sv =====
`timescale 1ns / 100ps
// tb_pose_record_hash: stimulus and verdict for pose_record_hash
// depends on prh_pkg, the block itself and prh_hash_checker

module tb_pose_record_hash;
   import prh_pkg::*;

   localparam logic [CountWidth-1:0] CountFull = 3'd4;
   localparam int unsigned ItemTarget = 1250;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqWidth-1:0]    req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LengthWidth-1:0] csr_wdata = '0;

   int unsigned failures;
   int unsigned pending;
   int unsigned items_sent;
   bit          calm;        // both sides run without gaps
   bit          choke;       // receiver holds off for a long stretch

   pose_record_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   prh_hash_checker hash_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   initial begin
      #10_000_000;
      $display("tb_pose_record_hash: errors");
      $finish;
   end

   function automatic int unsigned idle_cycles();
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // mostly random words, now and then a sign corner
   function automatic word_type pick_word();
      if ($urandom_range(0, 7) != 0)
         return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_8000;
         default: return 32'h7FFF_7FFF;
      endcase
   endfunction

   // one word per transfer; valid stays high when the next word follows at once
   task automatic send_word(input word_type word, input logic [CountWidth-1:0] count,
                            input logic last);
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, count, word};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // mostly well-formed messages, the rest with random byte counts
   task automatic send_message(input bit noisy);
      int unsigned words;
      logic [CountWidth-1:0] count;
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
      for (int unsigned i = 0; i < words; i++) begin
         if (noisy)
            count = CountWidth'($urandom_range(0, 7));
         else if (i == words - 1)
            count = CountWidth'($urandom_range(1, 4));
         else
            count = CountFull;
         send_word(pick_word(), count, i == words - 1);
      end
   endtask

   // wait for every hash, then let the pipeline run dry
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_length(input logic [LengthWidth-1:0] len);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, one long hold-off when asked
   initial begin
      int unsigned gap;
      bit          held_off;
      held_off = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (choke && !held_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            held_off = 1'b1;
         end
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // stimulus and verdict
   initial begin
      int unsigned pick;
      logic [LengthWidth-1:0] len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset length, each byte-count rule and sign corners
      send_word(32'h0000_0000, CountFull, 1'b1);
      send_word(32'hFFFF_FFFF, CountFull, 1'b0);
      send_word(32'h8000_8000, CountThree, 1'b1);
      send_word(32'h7FFF_7FFF, CountFull, 1'b0);
      send_word(32'h0000_FFFF, CountTwo, 1'b1);
      send_word(32'h0000_00FF, CountOne, 1'b1);
      // empty last word: avalanche only
      send_word(32'h1234_5678, CountNone, 1'b1);
      // oversized counts on a last word act as full words
      send_word(32'hDEAD_BEEF, 3'd5, 1'b1);
      send_word(32'hCAFE_F00D, 3'd6, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
      // count ignored on words that are not last
      send_word(32'hA5A5_A5A5, CountOne, 1'b0);
      send_word(32'h5A5A_5A5A, CountNone, 1'b0);
      send_word(32'h0080_0080, CountThree, 1'b1);
      // zero length forces a zero hash
      set_length('0);
      send_word(32'hFFFF_FFFF, CountFull, 1'b0);
      send_word(32'h1357_9BDF, CountFull, 1'b1);
      set_length('1);
      send_word(32'h8000_0000, CountFull, 1'b0);
      send_word(32'h7FFF_FFFF, CountTwo, 1'b1);
      send_word(32'h0000_0080, CountOne, 1'b1);
      set_length(16'd1);
      send_word(32'hFEDC_BA98, CountThree, 1'b1);

      // long receiver hold-off while single-word messages keep coming
      drain();
      calm  = 1'b1;
      choke = 1'b1;
      repeat (24) send_word(pick_word(), CountWidth'($urandom_range(1, 4)), 1'b1);

      // random phases with occasional length changes
      while (items_sent < ItemTarget) begin
         if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0:       len = '0;
               1:       len = '1;
               2:       len = 16'd1;
               3:       len = LengthReset;
               default: len = LengthWidth'($urandom);
            endcase
            set_length(len);
         end
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 8))
            send_message($urandom_range(0, 4) == 0);
         drain();
      end

      drain();
      if (failures == 0 && pending == 0)
         $display("tb_pose_record_hash: clean");
      else
         $display("tb_pose_record_hash: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/prh_pkg.sv
rtl/core/prh_round.sv
rtl/core/prh_finish.sv
rtl/core/pose_record_hash.sv
tb/prh_hash_checker.sv
tb/tb_pose_record_hash.sv
